[rtl/iprl_pkg.sv]
// Shared types and constants for the IPv4 route lookup block.
// No dependencies; used by iprl_cell and ipv4_route_lookup_forward_top.
`default_nettype none

package iprl_pkg;

    // Default number of table slots
    localparam int unsigned TABLE_SIZE_DEF = 16;

    // Field widths fixed by the item format
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned IFACE_W = 4;
    localparam int unsigned TTL_W   = 8;
    localparam int unsigned VERD_W  = 2;

    // Item actions
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_FORWARD = 1'b1;

    // Verdict codes
    localparam logic [VERD_W-1:0] V_FORWARD = 2'd0;
    localparam logic [VERD_W-1:0] V_EXPIRED = 2'd1;
    localparam logic [VERD_W-1:0] V_NOROUTE = 2'd2;
    localparam logic [VERD_W-1:0] V_WRITTEN = 2'd3;

    // Control states of the top level
    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    // Table write broadcast to every cell
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gateway;
        logic [IFACE_W-1:0] iface;
    } wr_t;

    // Search record handed from cell to cell
    typedef struct packed {
        logic               active;
        logic [ADDR_W-1:0]  dst;
        logic [ADDR_W-1:0]  best_mask;
        logic [IDX_W-1:0]   best_idx;
        logic [ADDR_W-1:0]  best_gw;
        logic [IFACE_W-1:0] best_iface;
        logic               dflt_found;
        logic [IDX_W-1:0]   dflt_idx;
        logic [ADDR_W-1:0]  dflt_gw;
        logic [IFACE_W-1:0] dflt_iface;
    } chain_t;

endpackage

`default_nettype wire

[rtl/iprl_cell.sv]
// One routing table slot plus one stage of the search chain.
// Depends on iprl_pkg for the write and search record types.
`default_nettype none

module iprl_cell #(
    parameter int unsigned CELL_ID = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire iprl_pkg::wr_t   wr,
    input  wire iprl_pkg::chain_t chain_in,
    output iprl_pkg::chain_t     chain_out
);

    import iprl_pkg::*;

    localparam logic [IDX_W-1:0] ID_BITS = IDX_W'(CELL_ID);

    logic               valid_reg;
    logic [ADDR_W-1:0]  dest_reg;
    logic [ADDR_W-1:0]  mask_reg;
    logic [ADDR_W-1:0]  gw_reg;
    logic [IFACE_W-1:0] iface_reg;

    logic               active_reg;
    chain_t             data_reg;
    chain_t             data_next;
    logic               match;
    logic               take_best;
    logic               take_dflt;

    // Store the slot valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= wr.valid;
        end
    end

    // Store the slot payload
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dest_reg  <= wr.dest;
            mask_reg  <= wr.mask;
            gw_reg    <= wr.gateway;
            iface_reg <= wr.iface;
        end
    end

    // Compare this slot against the record passing through
    assign match     = valid_reg && ((chain_in.dst & mask_reg) == (dest_reg & mask_reg));
    assign take_best = match && (mask_reg > chain_in.best_mask);
    assign take_dflt = valid_reg && (dest_reg == '0) && !chain_in.dflt_found;

    // Update the best and default candidates
    always_comb
    begin
        data_next = chain_in;
        if (take_best)
        begin
            data_next.best_mask  = mask_reg;
            data_next.best_idx   = ID_BITS;
            data_next.best_gw    = gw_reg;
            data_next.best_iface = iface_reg;
        end
        if (take_dflt)
        begin
            data_next.dflt_found = 1'b1;
            data_next.dflt_idx   = ID_BITS;
            data_next.dflt_gw    = gw_reg;
            data_next.dflt_iface = iface_reg;
        end
    end

    // Advance the token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= chain_in.active;
        end
    end

    // Advance the record payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        chain_out        = data_reg;
        chain_out.active = active_reg;
    end

endmodule

`default_nettype wire

[rtl/ipv4_route_lookup_forward_top.sv]
// IPv4 longest prefix match lookup: write items give their result on the next cycle.
// A forward item with live TTL walks one cell per cycle through the cell chain to the result
// registers; busy holds off further items until the search record leaves the chain.
// Expired TTL and write items are answered in the next cycle; busy stays low for them.
// Reset clears all slot valid bits and the control state; the receiver cannot stall.
// Depends on iprl_pkg and iprl_cell.
`default_nettype none

module ipv4_route_lookup_forward_top #(
    parameter int unsigned TABLE_SIZE = iprl_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          action,
    input  wire logic [iprl_pkg::IDX_W-1:0]    entry_index,
    input  wire logic                          entry_valid,
    input  wire logic [iprl_pkg::ADDR_W-1:0]   route_dest,
    input  wire logic [iprl_pkg::ADDR_W-1:0]   route_mask,
    input  wire logic [iprl_pkg::ADDR_W-1:0]   route_gateway,
    input  wire logic [iprl_pkg::IFACE_W-1:0]  route_iface,
    input  wire logic [iprl_pkg::ADDR_W-1:0]   dest_addr,
    input  wire logic [iprl_pkg::TTL_W-1:0]    ttl_in,
    output logic                               done,
    output logic [iprl_pkg::VERD_W-1:0]        verdict,
    output logic [iprl_pkg::ADDR_W-1:0]        next_hop,
    output logic [iprl_pkg::IFACE_W-1:0]       out_iface,
    output logic [iprl_pkg::TTL_W-1:0]         ttl_out,
    output logic [iprl_pkg::IDX_W-1:0]         hit_index
);

    import iprl_pkg::*;

    state_t              state_reg;
    state_t              state_next;

    logic                take;
    logic                write_go;
    logic                expire_go;
    logic                lookup_go;

    wr_t                 wr;
    logic [TABLE_SIZE-1:0] wr_en;
    chain_t              chain [0:TABLE_SIZE];
    chain_t              tail;
    logic [TABLE_SIZE-1:0] token_vec;

    logic [TTL_W-1:0]    ttl_reg;
    logic [TTL_W-1:0]    ttl_dec;

    logic                done_reg;
    logic                done_next;
    logic [VERD_W-1:0]   verdict_reg;
    logic [VERD_W-1:0]   verdict_next;
    logic [ADDR_W-1:0]   next_hop_reg;
    logic [ADDR_W-1:0]   next_hop_next;
    logic [IFACE_W-1:0]  iface_reg;
    logic [IFACE_W-1:0]  iface_next;
    logic [TTL_W-1:0]    ttl_out_reg;
    logic [TTL_W-1:0]    ttl_out_next;
    logic [IDX_W-1:0]    hit_reg;
    logic [IDX_W-1:0]    hit_next;
    logic [ADDR_W-1:0]   sel_gw;

    // Decode the incoming transfer
    assign take      = start && !busy;
    assign write_go  = take && (action == ACT_WRITE);
    assign expire_go = take && (action == ACT_FORWARD) && (ttl_in <= TTL_W'(1));
    assign lookup_go = take && (action == ACT_FORWARD) && (ttl_in > TTL_W'(1));
    assign ttl_dec   = ttl_in - TTL_W'(1);

    // Broadcast the table write
    always_comb
    begin
        wr.valid   = entry_valid;
        wr.dest    = route_dest;
        wr.mask    = route_mask;
        wr.gateway = route_gateway;
        wr.iface   = route_iface;
    end

    // Seed the search record at the head of the chain
    always_comb
    begin
        chain[0]            = '0;
        chain[0].active     = lookup_go;
        chain[0].dst        = dest_addr;
    end

    // Build the chain of slot cells
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_SIZE; gi++)
        begin : g_cell
            assign wr_en[gi]     = write_go && (32'(entry_index) == 32'(gi));
            assign token_vec[gi] = chain[gi+1].active;

            iprl_cell #(
                .CELL_ID (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (wr_en[gi]),
                .wr        (wr),
                .chain_in  (chain[gi]),
                .chain_out (chain[gi+1])
            );
        end
    endgenerate

    assign tail = chain[TABLE_SIZE];

    // Hold the decremented TTL for the lookup in flight
    always_ff @(posedge clk)
    begin
        if (lookup_go)
        begin
            ttl_reg <= ttl_dec;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (lookup_go)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tail.active)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        case (state_reg)
            ST_SEARCH: busy = 1'b1;
            default:   busy = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Form the result
    always_comb
    begin
        done_next     = 1'b0;
        verdict_next  = V_FORWARD;
        next_hop_next = '0;
        iface_next    = '0;
        ttl_out_next  = '0;
        hit_next      = '0;
        sel_gw        = '0;
        if (write_go)
        begin
            done_next    = 1'b1;
            verdict_next = V_WRITTEN;
            hit_next     = entry_index;
        end
        else if (expire_go)
        begin
            done_next    = 1'b1;
            verdict_next = V_EXPIRED;
        end
        else if (tail.active)
        begin
            done_next    = 1'b1;
            ttl_out_next = ttl_reg;
            if (tail.best_mask != '0)
            begin
                sel_gw     = tail.best_gw;
                iface_next = tail.best_iface;
                hit_next   = tail.best_idx;
            end
            else if (tail.dflt_found)
            begin
                sel_gw     = tail.dflt_gw;
                iface_next = tail.dflt_iface;
                hit_next   = tail.dflt_idx;
            end
            else
            begin
                verdict_next = V_NOROUTE;
            end
            if (verdict_next == V_FORWARD)
            begin
                next_hop_next = (sel_gw != '0) ? sel_gw : tail.dst;
            end
        end
    end

    // Drive the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Register the result payload
    always_ff @(posedge clk)
    begin
        verdict_reg  <= verdict_next;
        next_hop_reg <= next_hop_next;
        iface_reg    <= iface_next;
        ttl_out_reg  <= ttl_out_next;
        hit_reg      <= hit_next;
    end

    assign done      = done_reg;
    assign verdict   = verdict_reg;
    assign next_hop  = next_hop_reg;
    assign out_iface = iface_reg;
    assign ttl_out   = ttl_out_reg;
    assign hit_index = hit_reg;

    // At most one search token travels the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(token_vec))
        else $error("more than one search token in the chain");

    // A token only travels while the block is searching
    a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (token_vec != '0) |-> (state_reg == ST_SEARCH))
        else $error("search token outside the search state");

    // The token leaving the chain yields a result strobe
    a_tail_done: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |=> done_reg)
        else $error("lookup finished without a result");

    // A taken lookup holds off new items
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_go |=> busy)
        else $error("busy not raised after a lookup transfer");

    // A forwarded packet always leaves with a live TTL
    a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (verdict_reg == V_FORWARD)) |-> (ttl_out_reg != '0))
        else $error("forward verdict with zero TTL");

endmodule

`default_nettype wire
